/* sv/slpq_pkg.sv */
`timescale 1ns / 1ps

package slpq_pkg;

  localparam int unsigned DataW = 32;

  // Configuration register index (paddr[2])
  localparam logic REG_ORDER_MODE = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_HEADNXT,
    S_WALK,
    S_LINKPOS,
    S_REM,
    S_REMPAIR,
    S_SEARCH
  } state_e;

  typedef struct packed {
    logic        [1:0]       command;
    logic signed [DataW-1:0] element_value;
    logic signed [DataW-1:0] priority_value;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] head_value;
    logic signed [DataW-1:0] head_priority;
    logic                    found;
    logic                    is_empty;
    logic        [1:0]       status;
  } out_t;

  // True when priority a sits at or ahead of priority b.
  function automatic logic goes_first(input logic mode,
                                      input logic signed [DataW-1:0] a,
                                      input logic signed [DataW-1:0] b);
    return mode ? (a >= b) : (a <= b);
  endfunction

endpackage

/* sv/slpq_ram.sv */
`timescale 1ns / 1ps

module slpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/slpq_ctrl.sv */
`timescale 1ns / 1ps

module slpq_ctrl #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              order_mode_i,
  input  logic                              start_i,
  input  slpq_pkg::in_t                     cmd_i,
  output logic                              busy_o,
  output logic                              done_o,
  output slpq_pkg::out_t                    result_o,
  // pair store: {value, priority}
  output logic                              pr_we_o,
  output logic [$clog2(CAPACITY)-1:0]       pr_waddr_o,
  output logic [2*slpq_pkg::DataW-1:0]      pr_wdata_o,
  output logic                              pr_re_o,
  output logic [$clog2(CAPACITY)-1:0]       pr_raddr_o,
  input  logic [2*slpq_pkg::DataW-1:0]      pr_rdata_i,
  // link store
  output logic                              lk_we_o,
  output logic [$clog2(CAPACITY)-1:0]       lk_waddr_o,
  output logic [$clog2(CAPACITY+1)-1:0]     lk_wdata_o,
  output logic                              lk_re_o,
  output logic [$clog2(CAPACITY)-1:0]       lk_raddr_o,
  input  logic [$clog2(CAPACITY+1)-1:0]     lk_rdata_i
);

  import slpq_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [SW-1:0] NONE = SW'(CAPACITY);

  state_e state_q, state_d;
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] free_q, free_d;
  logic [SW-1:0] fresh_q, fresh_d;   // slots at and above this were never handed out
  logic [SW-1:0] count_q, count_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] pos_q, pos_d;
  logic [SW-1:0] nxt_q, nxt_d;
  logic signed [DataW-1:0] val_q, val_d, pri_q, pri_d;
  logic signed [DataW-1:0] hval_q, hval_d, hpri_q, hpri_d;
  out_t res_q, res_d;
  logic res_valid_q;

  logic do_place, do_step;
  logic [SW-1:0] place_s, cand;
  logic signed [DataW-1:0] place_v, place_p;
  logic fin, fin_found, fin_removed;
  status_e fin_status;
  logic signed [DataW-1:0] rd_val, rd_pri;

  assign rd_val = $signed(pr_rdata_i[2*DataW-1:DataW]);
  assign rd_pri = $signed(pr_rdata_i[DataW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NONE;
      free_q      <= '0;
      fresh_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      res_valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    pos_q  <= pos_d;
    nxt_q  <= nxt_d;
    val_q  <= val_d;
    pri_q  <= pri_d;
    hval_q <= hval_d;
    hpri_q <= hpri_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    free_d  = free_q;
    fresh_d = fresh_q;
    count_d = count_q;
    slot_d  = slot_q;
    pos_d   = pos_q;
    nxt_d   = nxt_q;
    val_d   = val_q;
    pri_d   = pri_q;
    hval_d  = hval_q;
    hpri_d  = hpri_q;

    pr_we_o    = 1'b0;
    pr_waddr_o = '0;
    pr_wdata_o = '0;
    pr_re_o    = 1'b0;
    pr_raddr_o = '0;
    lk_we_o    = 1'b0;
    lk_waddr_o = '0;
    lk_wdata_o = '0;
    lk_re_o    = 1'b0;
    lk_raddr_o = '0;

    do_place    = 1'b0;
    do_step     = 1'b0;
    cand        = NONE;
    fin         = 1'b0;
    fin_found   = 1'b0;
    fin_removed = 1'b0;
    fin_status  = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d = cmd_i.element_value;
          pri_d = cmd_i.priority_value;
          unique case (cmd_e'(cmd_i.command))
            CMD_ADD: begin
              if (count_q == NONE || free_q == NONE) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                pr_we_o    = 1'b1;
                pr_waddr_o = free_q[AW-1:0];
                pr_wdata_o = {cmd_i.element_value, cmd_i.priority_value};
                slot_d     = free_q;
                count_d    = count_q + SW'(1);
                if (free_q == fresh_q) begin
                  // untouched slot: its successor on the free list is the next one
                  fresh_d  = fresh_q + SW'(1);
                  free_d   = fresh_q + SW'(1);
                  do_place = 1'b1;
                end else begin
                  lk_re_o    = 1'b1;
                  lk_raddr_o = free_q[AW-1:0];
                  state_d    = S_ALLOC;
                end
              end
            end
            CMD_REMOVE: begin
              if (head_q == NONE) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                lk_re_o    = 1'b1;
                lk_raddr_o = head_q[AW-1:0];
                val_d      = hval_q;
                pri_d      = hpri_q;
                state_d    = S_REM;
              end
            end
            CMD_SEARCH: begin
              if (head_q == NONE) begin
                fin = 1'b1;
              end else begin
                pr_re_o    = 1'b1;
                pr_raddr_o = head_q[AW-1:0];
                lk_re_o    = 1'b1;
                lk_raddr_o = head_q[AW-1:0];
                state_d    = S_SEARCH;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        free_d   = lk_rdata_i;
        do_place = 1'b1;
      end

      S_HEADNXT: begin
        cand    = lk_rdata_i;
        do_step = 1'b1;
      end

      S_WALK: begin
        if (goes_first(order_mode_i, rd_pri, pri_q)) begin
          pos_d   = nxt_q;
          cand    = lk_rdata_i;
          do_step = 1'b1;
        end else begin
          lk_we_o    = 1'b1;
          lk_waddr_o = slot_q[AW-1:0];
          lk_wdata_o = nxt_q;
          state_d    = S_LINKPOS;
        end
      end

      S_LINKPOS: begin
        lk_we_o    = 1'b1;
        lk_waddr_o = pos_q[AW-1:0];
        lk_wdata_o = slot_q;
        fin        = 1'b1;
        state_d    = S_IDLE;
      end

      S_REM: begin
        // old head goes back on the free list
        lk_we_o    = 1'b1;
        lk_waddr_o = head_q[AW-1:0];
        lk_wdata_o = free_q;
        free_d     = head_q;
        count_d    = count_q - SW'(1);
        head_d     = lk_rdata_i;
        if (lk_rdata_i == NONE) begin
          fin         = 1'b1;
          fin_removed = 1'b1;
          state_d     = S_IDLE;
        end else begin
          pr_re_o    = 1'b1;
          pr_raddr_o = lk_rdata_i[AW-1:0];
          state_d    = S_REMPAIR;
        end
      end

      S_REMPAIR: begin
        hval_d      = rd_val;
        hpri_d      = rd_pri;
        fin         = 1'b1;
        fin_removed = 1'b1;
        state_d     = S_IDLE;
      end

      S_SEARCH: begin
        if (rd_val == val_q) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          state_d   = S_IDLE;
        end else if (lk_rdata_i == NONE) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          pr_re_o    = 1'b1;
          pr_raddr_o = lk_rdata_i[AW-1:0];
          lk_re_o    = 1'b1;
          lk_raddr_o = lk_rdata_i[AW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // new slot goes in front of the head, or the walk starts at the head
    place_s = (state_q == S_IDLE) ? free_q : slot_q;
    place_v = (state_q == S_IDLE) ? cmd_i.element_value : val_q;
    place_p = (state_q == S_IDLE) ? cmd_i.priority_value : pri_q;
    if (do_place) begin
      if (head_q == NONE || goes_first(order_mode_i, place_p, hpri_q)) begin
        lk_we_o    = 1'b1;
        lk_waddr_o = place_s[AW-1:0];
        lk_wdata_o = head_q;
        head_d     = place_s;
        hval_d     = place_v;
        hpri_d     = place_p;
        fin        = 1'b1;
        state_d    = S_IDLE;
      end else begin
        lk_re_o    = 1'b1;
        lk_raddr_o = head_q[AW-1:0];
        pos_d      = head_q;
        state_d    = S_HEADNXT;
      end
    end

    // one walk step: end of list links in at the tail, else fetch the candidate
    if (do_step) begin
      if (cand == NONE) begin
        lk_we_o    = 1'b1;
        lk_waddr_o = slot_q[AW-1:0];
        lk_wdata_o = NONE;
        state_d    = S_LINKPOS;
      end else begin
        pr_re_o    = 1'b1;
        pr_raddr_o = cand[AW-1:0];
        lk_re_o    = 1'b1;
        lk_raddr_o = cand[AW-1:0];
        nxt_d      = cand;
        state_d    = S_WALK;
      end
    end
  end

  always_comb begin
    res_d          = res_q;
    if (fin) begin
      res_d.found    = fin_found;
      res_d.status   = fin_status;
      res_d.is_empty = (head_d == NONE);
      if (fin_removed) begin
        res_d.head_value    = val_q;
        res_d.head_priority = pri_q;
      end else if (head_d == NONE) begin
        res_d.head_value    = '0;
        res_d.head_priority = '0;
      end else begin
        res_d.head_value    = hval_d;
        res_d.head_priority = hpri_d;
      end
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = res_valid_q;
  assign result_o = res_q;

endmodule

/* sv/sorted_list_priority_queue.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             cmd_i    (slpq_pkg::in_t)
// result    out        done_o, one cycle wide    result_o (slpq_pkg::out_t)
// config    in         APB write, pready tied 1  pwdata[0] -> order_mode
//
// Adds and searches are bound by the list walk: one linked slot per cycle
// through the link memory. The result beat is registered and shows in the
// cycle after the last step.
// Reset: empty queue, free list 0,1,2 onward built lazily, no clearing pass.
// The receiver cannot stall: each result beat is valid for one cycle only.

module sorted_list_priority_queue #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // command channel
  input  logic           start,
  output logic           busy,
  input  slpq_pkg::in_t  cmd_i,
  // result channel
  output logic           done_o,
  output slpq_pkg::out_t result_o,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  import slpq_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  // Order relation register
  logic order_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ORDER_MODE) begin
      order_mode_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ORDER_MODE) ? {31'd0, order_mode_q} : 32'd0;

  // Memory ports
  logic                 pr_we, pr_re;
  logic [AW-1:0]        pr_waddr, pr_raddr;
  logic [2*DataW-1:0]   pr_wdata, pr_rdata;
  logic                 lk_we, lk_re;
  logic [AW-1:0]        lk_waddr, lk_raddr;
  logic [SW-1:0]        lk_wdata, lk_rdata;

  // (value, priority) of each slot
  slpq_ram #(
    .Width (2 * DataW),
    .Depth (CAPACITY)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_waddr),
    .wdata_i (pr_wdata),
    .re_i    (pr_re),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  // Successor of each slot, on the queue list or on the free list
  slpq_ram #(
    .Width (SW),
    .Depth (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  // Sequencer: allocation, sorted insert walk, pop, search
  slpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .order_mode_i (order_mode_q),
    .start_i      (start),
    .cmd_i        (cmd_i),
    .busy_o       (busy),
    .done_o       (done_o),
    .result_o     (result_o),
    .pr_we_o      (pr_we),
    .pr_waddr_o   (pr_waddr),
    .pr_wdata_o   (pr_wdata),
    .pr_re_o      (pr_re),
    .pr_raddr_o   (pr_raddr),
    .pr_rdata_i   (pr_rdata),
    .lk_we_o      (lk_we),
    .lk_waddr_o   (lk_waddr),
    .lk_wdata_o   (lk_wdata),
    .lk_re_o      (lk_re),
    .lk_raddr_o   (lk_raddr),
    .lk_rdata_i   (lk_rdata)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import slpq_pkg::*;

  localparam int CAP = 32;
  localparam int NIL = CAP;                 // end-of-list marker in the shadow links
  localparam logic [1:0] CMD_UNUSED = 2'd3; // no-op command, reports the head
  localparam logic [2:0] ORDER_ADDR = {REG_ORDER_MODE, 2'b00};
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int IDLE_LIMIT = 4000;         // cycles with no command or result beat
  localparam int DRAIN_CYCLES = CAP + 8;    // worst walk plus the result beat

  // Directed stimulus row; want is used only when typed is set.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] val;
    logic [31:0] pri;
    bit          typed;
    out_t        want;
  } stim_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  in_t         cmd_i   = '0;
  logic        done_o;
  out_t        result_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the queue: slot memories, links, head, free list, count.
  logic signed [31:0] sh_val  [CAP];
  logic signed [31:0] sh_pri  [CAP];
  int                 sh_link [CAP];
  int                 sh_head;
  int                 sh_free;
  int                 sh_count;
  logic               sh_order;

  out_t pending_heads [$];   // expected result beats, oldest first

  int  n_items, n_beats, n_errors, n_full, n_empty_pops, n_hits, idle_cycles;
  bit  burst_mode;

  sorted_list_priority_queue #(.CAPACITY(CAP)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_bad(input string msg);
    if (n_errors < 60) $display("[%0t] ERROR %s", $time, msg);
    n_errors++;
  endtask

  // Priority a sits at or ahead of b under the current relation.
  function automatic logic ranks_ahead(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    return sh_order ? (a >= b) : (a <= b);
  endfunction

  // Apply one command to the shadow queue and return the beat it must produce.
  function automatic out_t shadow_step(input in_t it);
    out_t r;
    int   slot, pos, steps;
    logic report_head;
    r = '0;
    report_head = 1'b1;
    case (it.command)
      CMD_ADD: begin
        if (sh_count >= CAP || sh_free >= CAP) begin
          r.status = ST_FULL;   // pair dropped
          n_full++;
        end else begin
          slot = sh_free;
          sh_free = sh_link[slot];
          sh_val[slot] = it.element_value;
          sh_pri[slot] = it.priority_value;
          sh_link[slot] = NIL;
          sh_count++;
          if (sh_head == NIL) begin
            sh_head = slot;
          end else if (ranks_ahead(it.priority_value, sh_pri[sh_head])) begin
            // ties with the head go in front of it
            sh_link[slot] = sh_head;
            sh_head = slot;
          end else begin
            // ties further down go behind every equal entry
            pos = sh_head;
            steps = 0;
            while (steps < CAP && sh_link[pos] != NIL &&
                   ranks_ahead(sh_pri[sh_link[pos]], it.priority_value)) begin
              pos = sh_link[pos];
              steps++;
            end
            sh_link[slot] = sh_link[pos];
            sh_link[pos] = slot;
          end
        end
      end
      CMD_REMOVE: begin
        if (sh_head == NIL) begin
          r.status = ST_EMPTY;
          n_empty_pops++;
        end else begin
          slot = sh_head;
          r.head_value = sh_val[slot];
          r.head_priority = sh_pri[slot];
          sh_head = sh_link[slot];
          sh_link[slot] = sh_free;
          sh_free = slot;
          sh_count--;
          report_head = 1'b0;   // the popped pair is reported, not the new head
        end
      end
      CMD_SEARCH: begin
        pos = sh_head;
        steps = 0;
        while (steps < CAP && pos != NIL && !r.found) begin
          if (sh_val[pos] == it.element_value) r.found = 1'b1;
          pos = sh_link[pos];
          steps++;
        end
        if (r.found) n_hits++;
      end
      default: ;
    endcase
    if (report_head && sh_head != NIL) begin
      r.head_value = sh_val[sh_head];
      r.head_priority = sh_pri[sh_head];
    end
    r.is_empty = (sh_head == NIL);
    return r;
  endfunction

  // Issue one command beat; start stays up across back-to-back beats.
  task automatic send_item(input in_t it, input bit typed, input out_t lit);
    out_t want;
    int   r;
    start <= 1'b1;
    cmd_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = shadow_step(it);
    pending_heads.push_back(typed ? lit : want);
    n_items++;
    r = $urandom_range(99);
    if (!burst_mode && r >= 60) begin
      start <= 1'b0;
      if (r < 90)      repeat ($urandom_range(3, 1)) @(posedge clk_i);
      else if (r < 98) repeat ($urandom_range(10, 4)) @(posedge clk_i);
      else             repeat ($urandom_range(40, 20)) @(posedge clk_i);
    end
  endtask

  // Drop start and hold off until every pending beat is back and the walk is over.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_heads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of order_mode, then a read back of the kept bit.
  task automatic write_order(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ORDER_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sh_order = data[0];
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== sh_order)
      report_bad($sformatf("order_mode read back %b, wrote %b", prdata[0], sh_order));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] corner_word(input int idx);
    case (idx)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Random commands with a given add/remove mix; the rest are searches and a few no-ops.
  task automatic run_phase(input int add_pct, input int rem_pct, input int count);
    in_t it;
    int  r, pos, hops;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < add_pct)                it.command = CMD_ADD;
      else if (r < add_pct + rem_pct) it.command = CMD_REMOVE;
      else if (r < 96)                it.command = CMD_SEARCH;
      else                            it.command = CMD_UNUSED;

      r = $urandom_range(9);
      if (r < 5)      it.element_value = $urandom_range(15) - 8;  // small pool, repeats
      else if (r < 9) it.element_value = $urandom;
      else            it.element_value = corner_word($urandom_range(3));

      r = $urandom_range(19);
      if (r < 8)       it.priority_value = $urandom_range(8) - 4;  // lots of ties
      else if (r < 17) it.priority_value = $urandom;
      else             it.priority_value = corner_word($urandom_range(3));

      // most searches look for something that is really in the list
      if (it.command == CMD_SEARCH && sh_count > 0 && $urandom_range(2) != 0) begin
        hops = $urandom_range(sh_count - 1);
        pos = sh_head;
        repeat (hops) pos = sh_link[pos];
        it.element_value = sh_val[pos];
      end

      send_item(it, 1'b0, '0);
      if ($urandom_range(199) == 0) settle();   // occasional full drain mid-phase
    end
  endtask

  // Result beats: one cycle wide, no back-pressure, checked against the oldest entry.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && done_o) begin
      n_beats++;
      if (pending_heads.size() == 0) begin
        report_bad("result beat with no command outstanding");
      end else begin
        want = pending_heads.pop_front();
        if (result_o.head_value !== want.head_value)
          report_bad($sformatf("beat %0d head_value %h, want %h",
                               n_beats, result_o.head_value, want.head_value));
        if (result_o.head_priority !== want.head_priority)
          report_bad($sformatf("beat %0d head_priority %h, want %h",
                               n_beats, result_o.head_priority, want.head_priority));
        if (result_o.found !== want.found)
          report_bad($sformatf("beat %0d found %b, want %b",
                               n_beats, result_o.found, want.found));
        if (result_o.is_empty !== want.is_empty)
          report_bad($sformatf("beat %0d is_empty %b, want %b",
                               n_beats, result_o.is_empty, want.is_empty));
        if (result_o.status !== want.status)
          report_bad($sformatf("beat %0d status %0d, want %0d",
                               n_beats, result_o.status, want.status));
      end
    end
  end

  // Watchdog: nothing accepted in either direction for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a beat", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Directed part, mode 0. Typed rows are the obvious ones: empty queue,
  // extremes on an otherwise empty list, remove on empty.
  stim_row_t dir_table [22] = '{
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1, ST_EMPTY}},
    '{CMD_SEARCH, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1, ST_OK}},
    '{CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
      '{32'h0, 32'h0, 1'b0, 1'b1, ST_OK}},
    '{CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
      '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, ST_OK}},
    // max priority lands behind the min-priority head
    '{CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
      '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, ST_OK}},
    '{CMD_ADD, 32'd5, 32'h8000_0000, 1'b0, '0},       // tie with head: new head
    '{CMD_SEARCH, 32'h8000_0000, 32'h0, 1'b0, '0},
    '{CMD_SEARCH, 32'h7fff_ffff, 32'h0, 1'b0, '0},
    '{CMD_SEARCH, 32'd12345, 32'h0, 1'b0, '0},        // miss
    '{CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
    '{CMD_ADD, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_ADD, 32'd1234, 32'h7fff_ffff, 1'b0, '0},     // tie at the tail
    '{CMD_SEARCH, 32'hffff_ffff, 32'h0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b0, '0},             // last one: now empty
    '{CMD_REMOVE, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1, ST_EMPTY}},
    '{CMD_SEARCH, 32'hffff_ffff, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1, ST_OK}}
  };

  // Phase mix: add-heavy phases fill to capacity, remove-heavy ones drain past empty.
  int          add_mix   [PHASES] = '{75, 60, 40, 25, 70, 45, 30, 55};
  int          rem_mix   [PHASES] = '{15, 25, 45, 60, 15, 40, 55, 30};
  logic [31:0] order_word[PHASES] = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_fffe,
                                      32'h0000_0001, 32'h0000_0000, 32'hffff_ffff,
                                      32'h0, 32'h0};

  initial begin
    in_t      it;
    out_t     lit;
    bit       mode_seen [2];
    for (int i = 0; i < CAP; i++) sh_link[i] = i + 1;
    sh_head = NIL;
    sh_free = 0;
    sh_count = 0;
    sh_order = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // upper bits set, bit 0 clear: relation stays at mode 0
    write_order(32'hffff_fffe);
    mode_seen[sh_order] = 1'b1;

    foreach (dir_table[i]) begin
      it.command = dir_table[i].cmd;
      it.element_value = dir_table[i].val;
      it.priority_value = dir_table[i].pri;
      lit = dir_table[i].want;
      send_item(it, dir_table[i].typed, lit);
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_order(p < 6 ? order_word[p] : $urandom);
      mode_seen[sh_order] = 1'b1;
      burst_mode = (p == 2 || p == 5);   // back-to-back commands, no sender gaps
      run_phase(add_mix[p], rem_mix[p], PHASE_ITEMS);
    end
    burst_mode = 1'b0;

    settle();

    $display("ran %0d commands, %0d result beats: %0d adds dropped full, %0d removes on empty,",
             n_items, n_beats, n_full, n_empty_pops);
    $display("%0d search hits, order modes exercised: %0d/2, %0d mismatches",
             n_hits, int'(mode_seen[0]) + int'(mode_seen[1]), n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
